// ===== design/cle_pkg.sv =====
package cle_pkg;

  localparam int IN_W     = 16;
  localparam int OUT_W    = 24;
  localparam int MAX_ECHO = 6;

  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_SP     = 8'h20;
  localparam logic [7:0] KEY_DEL    = 8'o177;
  localparam logic [7:0] KEY_CARET  = 8'h5E;
  localparam logic [7:0] KEY_LBRK   = 8'h5B;
  localparam logic [7:0] KEY_RBRK   = 8'h5D;
  localparam logic [7:0] KEY_U      = 8'h55;
  localparam logic [7:0] KEY_C      = 8'h43;
  localparam logic [7:0] CTRL_MASK  = 8'o037;
  localparam logic [7:0] KEY_CTRL_U = 8'h75 & CTRL_MASK;
  localparam logic [7:0] KEY_CTRL_C = 8'h63 & CTRL_MASK;

  typedef struct packed {
    logic                          ev;
    logic [2:0]                    cnt;
    logic [MAX_ECHO-1:0][7:0]      echo;
    logic                          done;
    logic                          ab;
    logic [5:0]                    len;
    logic                          intr;
    logic [6:0]                    rc;
  } cle_item_t;

endpackage

// ===== design/cle_ram.sv =====
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cle_edit.sv =====
module cle_edit #(
  parameter int LINE_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        acc,
  input  logic                        op,
  input  logic [7:0]                  key,
  input  logic [5:0]                  ridx,
  output cle_pkg::cle_item_t          item,
  output logic                        fetch,
  output logic                        ram_we,
  output logic [$clog2(LINE_LEN)-1:0] ram_waddr,
  output logic [6:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(LINE_LEN)-1:0] ram_raddr
);

  localparam int AW = $clog2(LINE_LEN);
  localparam int LW = ((AW > 6) ? AW : 6) + 1;

  logic [AW-1:0] wp_r, wp_nxt;
  logic          lc_r, lc_nxt;
  logic          intr_r, intr_nxt;
  logic          abort_r;

  logic [AW-1:0] wp0, wp_new;
  logic [7:0]    c1;
  logic          del, done, ab, store, we;
  logic [6:0]    m;
  logic [cle_pkg::MAX_ECHO-1:0][7:0] echo;
  logic [2:0]    n;
  logic [LW-1:0] ridx_ext, len_ext, len_rd_ext;
  logic          in_range;

  always_comb begin
    wp0      = lc_r ? '0 : wp_r;
    c1       = (key == cle_pkg::KEY_CR) ? cle_pkg::KEY_LF : key;
    del      = (c1 == cle_pkg::KEY_DEL) || (c1 == cle_pkg::KEY_BS);
    echo     = '0;
    n        = '0;
    done     = 1'b0;
    ab       = 1'b0;
    store    = 1'b0;
    we       = 1'b0;
    intr_nxt = intr_r;
    wp_new   = wp0;
    ram_waddr = wp0;
    if (del) begin
      echo[0] = cle_pkg::KEY_BS;
      echo[1] = cle_pkg::KEY_SP;
      echo[2] = cle_pkg::KEY_BS;
      n = 3'd3;
    end else if (c1 == cle_pkg::KEY_LF) begin
      echo[0] = cle_pkg::KEY_CR;
      echo[1] = cle_pkg::KEY_LF;
      n = 3'd2;
    end else begin
      echo[0] = key;
      n = 3'd1;
    end
    m = del ? cle_pkg::KEY_BS[6:0] : c1[6:0];
    if (((m == cle_pkg::KEY_LBRK[6:0]) || (m == cle_pkg::KEY_RBRK[6:0])) && (wp0 == '0)) begin
      we        = 1'b1;
      ram_waddr = '0;
      wp_new    = AW'(1);
      done      = 1'b1;
    end else if ((m == cle_pkg::KEY_LF[6:0]) || (m == cle_pkg::KEY_CR[6:0])) begin
      done = 1'b1;
    end else if (m == cle_pkg::KEY_BS[6:0]) begin
      if (wp0 != '0) begin
        wp_new = wp0 - AW'(1);
      end
    end else if (m == cle_pkg::KEY_CTRL_U[6:0]) begin
      wp_new = '0;
      echo[n] = cle_pkg::KEY_CARET;
      n = n + 3'd1;
      echo[n] = cle_pkg::KEY_U;
      n = n + 3'd1;
      echo[n] = cle_pkg::KEY_CR;
      n = n + 3'd1;
      echo[n] = cle_pkg::KEY_LF;
      n = n + 3'd1;
    end else if (m == cle_pkg::KEY_CTRL_C[6:0]) begin
      echo[n] = cle_pkg::KEY_CARET;
      n = n + 3'd1;
      echo[n] = cle_pkg::KEY_C;
      n = n + 3'd1;
      intr_nxt = 1'b1;
      if (abort_r) begin
        wp_new = '0;
        ab     = 1'b1;
      end else begin
        store = 1'b1;
      end
    end else begin
      store = 1'b1;
    end
    if (store) begin
      if (wp0 < AW'(LINE_LEN - 1)) begin
        we     = 1'b1;
        wp_new = wp0 + AW'(1);
      end else begin
        echo[n] = cle_pkg::KEY_BS;
        n = n + 3'd1;
        echo[n] = cle_pkg::KEY_SP;
        n = n + 3'd1;
        echo[n] = cle_pkg::KEY_BS;
        n = n + 3'd1;
      end
    end
  end

  assign ridx_ext   = LW'(ridx);
  assign in_range   = ridx_ext < LW'(LINE_LEN);
  assign len_ext    = LW'(wp_new);
  assign len_rd_ext = LW'(wp_r);

  always_comb begin
    if (op) begin
      item.ev   = 1'b0;
      item.cnt  = 3'd1;
      item.echo = '0;
      item.done = 1'b0;
      item.ab   = 1'b0;
      item.len  = len_rd_ext[5:0];
      item.intr = intr_r;
      item.rc   = '0;
    end else begin
      item.ev   = 1'b1;
      item.cnt  = n;
      item.echo = echo;
      item.done = done;
      item.ab   = ab;
      item.len  = len_ext[5:0];
      item.intr = intr_nxt;
      item.rc   = '0;
    end
  end

  assign fetch     = op && in_range;
  assign ram_we    = acc && !op && we;
  assign ram_wdata = m;
  assign ram_re    = acc && fetch;
  assign ram_raddr = ridx_ext[AW-1:0];

  assign wp_nxt = wp_new;
  assign lc_nxt = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      lc_r    <= 1'b0;
      intr_r  <= 1'b0;
      abort_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        abort_r <= cfg_wr_data;
      end
      if (acc && !op) begin
        wp_r   <= wp_nxt;
        lc_r   <= lc_nxt;
        intr_r <= intr_nxt;
      end
    end
  end

endmodule

// ===== design/cle_emit.sv =====
module cle_emit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ld,
  input  cle_pkg::cle_item_t       ld_item,
  input  logic                     ld_fetch,
  input  logic [6:0]               ram_q,
  output logic                     ld_rdy,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [cle_pkg::OUT_W-1:0] out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  cle_pkg::cle_item_t p_r, p_nxt, e_r, e_nxt, p_fixed;
  logic p_vld_r, p_vld_nxt, e_vld_r, e_vld_nxt, fix_r;
  logic e_fire, e_fin, move, last;

  assign last   = e_r.cnt == 3'd1;
  assign e_fire = e_vld_r && out_tready;
  assign e_fin  = e_fire && last;
  assign move   = p_vld_r && (!e_vld_r || e_fin);
  assign ld_rdy = !p_vld_r || move;

  always_comb begin
    p_fixed = p_r;
    if (fix_r) begin
      p_fixed.rc = ram_q;
    end
    p_nxt     = ld ? ld_item : p_fixed;
    p_vld_nxt = ld || (p_vld_r && !move);
    e_nxt     = e_r;
    if (move) begin
      e_nxt = p_fixed;
    end else if (e_fire) begin
      e_nxt.echo = e_r.echo >> 8;
      e_nxt.cnt  = e_r.cnt - 3'd1;
    end
    e_vld_nxt = move || (e_vld_r && !e_fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      fix_r   <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      e_vld_r <= e_vld_nxt;
      fix_r   <= ld && ld_fetch;
    end
    p_r <= p_nxt;
    e_r <= e_nxt;
  end

  assign out_tvalid = e_vld_r;
  assign out_tuser  = e_r.ev;
  assign out_tlast  = last;
  assign out_tdata  = {e_r.rc, e_r.intr, e_r.ab && last, e_r.len, e_r.done && last,
                       e_r.echo[0]};

endmodule

// ===== design/console_line_editor_core.sv =====
// Channel  Direction  Handshake              Word
// in_      slave      in_tvalid / in_tready  keystroke or line store read
// out_     master     out_tvalid / out_tready echo byte or read result
// cfg_     write      cfg_wr_en              abort enable register
//
// A keystroke produces one to six output words, one per cycle while out_tready is high; a read produces one.
// The first word of an item is presented once it has passed through the holding slot and the emit register.
// A read uses the line store's single registered read port in the cycle it is accepted.
// One item waits in a holding slot while the previous one is emitted; the input stalls
// while that slot is full and an item is being emitted whose last word the output is not taking.
// Reset clears the line length and flags; line store contents are not cleared.
module console_line_editor_core #(
  parameter int LINE_LEN = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cle_pkg::IN_W-1:0]  in_tdata,   // key_char, read_index
  input  logic [0:0]                in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cle_pkg::OUT_W-1:0] out_tdata,  // echo_char, line_done, line_length,
                                                // aborted, interrupted, read_char
  output logic [0:0]                out_tuser,  // echo_valid
  output logic                      out_tlast,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_wr_data
);

  localparam int AW = $clog2(LINE_LEN);

  cle_pkg::cle_item_t item;
  logic          in_fire, fetch, ram_we, ram_re, ld_rdy, ev;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [6:0]    ram_wdata, ram_q;

  assign in_tready = ld_rdy;
  assign in_fire   = in_tvalid && ld_rdy;

  cle_edit #(.LINE_LEN(LINE_LEN)) u_edit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data[0]),
    .acc        (in_fire),
    .op         (in_tuser[0]),
    .key        (in_tdata[7:0]),
    .ridx       (in_tdata[13:8]),
    .item       (item),
    .fetch      (fetch),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  cle_ram #(.WIDTH(7), .DEPTH(LINE_LEN)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  cle_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (in_fire),
    .ld_item   (item),
    .ld_fetch  (fetch),
    .ram_q     (ram_q),
    .ld_rdy    (ld_rdy),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (ev),
    .out_tlast (out_tlast)
  );

  assign out_tuser = ev;

  // The store is written by keystrokes and read by reads, never in the same cycle.
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("line store written and read in one cycle");

  // Every accepted keystroke yields between one and six echo words.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser[0] |-> (item.cnt != 3'd0) && (item.cnt <= 3'd6))
    else $error("keystroke echo count out of range");

  // A read result is always a single word.
  a_rd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("read result not marked last");

  // A keystroke cannot both complete and abort the line.
  a_done_ab: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[15]))
    else $error("line done and aborted together");

endmodule
